@@ rtl/dasd_pkg.sv @@
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared types, operation codes and calendar tables for the date register.
// ----------------------------------------------------------------------------
package dasd_pkg;

  // Operation codes carried on the request func field
  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_SUB = 2'd2;

  // Reset date
  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [15:0] RESET_YEAR  = 16'd2000;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  // Month lengths in a common year, January first
  localparam logic [11:0][4:0] MONTH_LEN = {
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
  };

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SET,
    CMD_LOAD,
    CMD_ADD,
    CMD_SUB
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic days_zero;
  } ctrl_status_t;

  // Build a 256-entry table of (i * step) mod 25, step below 25
  function automatic logic [255:0][4:0] build_mod25(input int unsigned step);
    logic [255:0][4:0] tab;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 5'(r);
      r = r + step;
      if (r >= 25) r = r - 25;
    end
    return tab;
  endfunction

  // Residues mod 25 of the low byte and of the high byte times 256
  localparam logic [255:0][4:0] MOD25_LO = build_mod25(1);
  localparam logic [255:0][4:0] MOD25_HI = build_mod25(256 % 25);

  // Gregorian leap test; divisible by 100 is divisible by 4 and by 25,
  // divisible by 400 is divisible by 16 and by 25
  function automatic logic is_leap(input logic [15:0] y);
    logic [5:0] s;
    logic       div25;
    s     = {1'b0, MOD25_HI[y[15:8]]} + {1'b0, MOD25_LO[y[7:0]]};
    div25 = (s == 6'd0) || (s == 6'd25);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // Days in month m (1..12); February follows the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[m - MONTH_JAN];
    end else begin
      len = MONTH_LEN[0];
    end
    return len;
  endfunction

endpackage

@@ rtl/date_add_subtract_days.sv @@
// ----------------------------------------------------------------------------
// date_add_subtract_days
// Gregorian date register with set, add-days and subtract-days requests.
// ----------------------------------------------------------------------------
// The block holds a date (reset 2000-01-01) and answers every request with
// the date held after it. A set or unused-code request goes from acceptance
// straight to the done state; an add or subtract of N days (N up to 65535)
// first runs the month step loop, which walks one calendar month per cycle.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted. The year wraps modulo 65536
// and year_wrapped_o flags a wrap within the request.
module date_add_subtract_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] days_count_i,
  input  logic [4:0]  new_day_i,
  input  logic [3:0]  new_month_i,
  input  logic [15:0] new_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [15:0] year_out_o,
  output logic        year_wrapped_o
);

  dasd_pkg::ctrl_cmd_t    cmd;
  dasd_pkg::ctrl_status_t status;

  // Sequence requests
  dasd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold and step the date
  dasd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .days_count_i   (days_count_i),
    .new_day_i      (new_day_i),
    .new_month_i    (new_month_i),
    .new_year_i     (new_year_i),
    .day_out_o      (day_out_o),
    .month_out_o    (month_out_o),
    .year_out_o     (year_out_o),
    .year_wrapped_o (year_wrapped_o)
  );

endmodule

@@ rtl/dasd_datapath.sv @@
// ----------------------------------------------------------------------------
// dasd_datapath
// Date registers, remaining day count and the one-month step logic.
// ----------------------------------------------------------------------------
module dasd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dasd_pkg::ctrl_cmd_t   cmd_i,
  output dasd_pkg::ctrl_status_t status_o,
  input  logic [15:0]           days_count_i,
  input  logic [4:0]            new_day_i,
  input  logic [3:0]            new_month_i,
  input  logic [15:0]           new_year_i,
  output logic [4:0]            day_out_o,
  output logic [3:0]            month_out_o,
  output logic [15:0]           year_out_o,
  output logic                  year_wrapped_o
);

  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [15:0] year_q, year_d;
  logic [15:0] days_q, days_d;
  logic        wrap_q, wrap_d;

  logic [4:0]  out_day_q;
  logic [3:0]  out_month_q;
  logic [15:0] out_year_q;
  logic        out_wrap_q;

  logic [4:0]  cur_len;
  logic [4:0]  prev_len;
  logic [4:0]  left;
  logic [3:0]  set_month;
  logic [4:0]  set_len;
  logic [4:0]  set_day;
  logic        cur_leap;

  // Month lengths for the held date and for the month before it
  always_comb begin
    cur_leap = dasd_pkg::is_leap(year_q);
    cur_len  = dasd_pkg::month_len(month_q, cur_leap);
    if (month_q == dasd_pkg::MONTH_JAN) begin
      prev_len = dasd_pkg::month_len(dasd_pkg::MONTH_DEC, 1'b0);
    end else begin
      prev_len = dasd_pkg::month_len(month_q - 4'd1, cur_leap);
    end
    left = cur_len - day_q;
  end

  // Clamp a written date into a valid one
  always_comb begin
    if (new_month_i < dasd_pkg::MONTH_JAN) begin
      set_month = dasd_pkg::MONTH_JAN;
    end else if (new_month_i > dasd_pkg::MONTH_DEC) begin
      set_month = dasd_pkg::MONTH_DEC;
    end else begin
      set_month = new_month_i;
    end
    set_len = dasd_pkg::month_len(set_month, dasd_pkg::is_leap(new_year_i));
    if (new_day_i == 5'd0) begin
      set_day = 5'd1;
    end else if (new_day_i > set_len) begin
      set_day = set_len;
    end else begin
      set_day = new_day_i;
    end
  end

  // Next state of the date and of the remaining count
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    days_d  = days_q;
    wrap_d  = wrap_q;
    case (cmd_i.op)
      dasd_pkg::CMD_SET: begin
        day_d   = set_day;
        month_d = set_month;
        year_d  = new_year_i;
        days_d  = '0;
        wrap_d  = 1'b0;
      end
      dasd_pkg::CMD_LOAD: begin
        days_d = days_count_i;
        wrap_d = 1'b0;
      end
      dasd_pkg::CMD_ADD: begin
        if (days_q > {11'd0, left}) begin
          // advance to the first of the next month
          days_d = days_q - {11'd0, left} - 16'd1;
          day_d  = 5'd1;
          if (month_q == dasd_pkg::MONTH_DEC) begin
            month_d = dasd_pkg::MONTH_JAN;
            year_d  = year_q + 16'd1;
            if (year_q == 16'hFFFF) wrap_d = 1'b1;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d  = day_q + days_q[4:0];
          days_d = '0;
        end
      end
      dasd_pkg::CMD_SUB: begin
        if (days_q >= {11'd0, day_q}) begin
          // drop back to the last day of the previous month
          days_d = days_q - {11'd0, day_q};
          day_d  = prev_len;
          if (month_q == dasd_pkg::MONTH_JAN) begin
            month_d = dasd_pkg::MONTH_DEC;
            year_d  = year_q - 16'd1;
            if (year_q == 16'd0) wrap_d = 1'b1;
          end else begin
            month_d = month_q - 4'd1;
          end
        end else begin
          day_d  = day_q - days_q[4:0];
          days_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= dasd_pkg::RESET_DAY;
      month_q <= dasd_pkg::RESET_MONTH;
      year_q  <= dasd_pkg::RESET_YEAR;
      days_q  <= '0;
      wrap_q  <= 1'b0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      days_q  <= days_d;
      wrap_q  <= wrap_d;
    end
  end

  // Capture the result for the output channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_day_q   <= day_q;
      out_month_q <= month_q;
      out_year_q  <= year_q;
      out_wrap_q  <= wrap_q;
    end
  end

  assign status_o.days_zero = (days_q == 16'd0);

  assign day_out_o      = out_day_q;
  assign month_out_o    = out_month_q;
  assign year_out_o     = out_year_q;
  assign year_wrapped_o = out_wrap_q;

endmodule

@@ rtl/dasd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer: accepts a request, steps the datapath one month per cycle on an
// add or subtract and hands the result to the output register.
// ----------------------------------------------------------------------------
module dasd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dasd_pkg::ctrl_cmd_t    cmd_o,
  input  dasd_pkg::ctrl_status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SUB  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequence the request
  always_comb begin
    state_d         = state_q;
    cmd_o.op        = dasd_pkg::CMD_NONE;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            dasd_pkg::FUNC_SET: begin
              cmd_o.op = dasd_pkg::CMD_SET;
              state_d  = S_DONE;
            end
            dasd_pkg::FUNC_ADD: begin
              cmd_o.op = dasd_pkg::CMD_LOAD;
              state_d  = S_ADD;
            end
            dasd_pkg::FUNC_SUB: begin
              cmd_o.op = dasd_pkg::CMD_LOAD;
              state_d  = S_SUB;
            end
            default: begin
              // unused code: date unchanged, wrap flag cleared
              cmd_o.op = dasd_pkg::CMD_LOAD;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_ADD: begin
        if (status_i.days_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = dasd_pkg::CMD_ADD;
        end
      end
      S_SUB: begin
        if (status_i.days_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = dasd_pkg::CMD_SUB;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Track the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date register.
// ----------------------------------------------------------------------------
// Drives set, add-days, subtract-days and unused-code requests into the
// block. Random gaps fall on the request side and random stalls on the result
// side, with one long result hold-off that fills the block. A date tracker
// predicts every returned date and compares it field by field, in order.
module tb_top;

  // Unused operation code: the date is returned unchanged
  localparam logic [1:0] FUNC_NOP = 2'd3;

  localparam int MAX_GAP       = 12;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 250;
  localparam int DRAIN_CYCLES  = 50;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        wrapped;
  } date_result_t;

  // Tracks the held date and queues the date each request should return
  class date_tracker;
    int unsigned   cur_day;
    int unsigned   cur_month;
    logic [15:0]   cur_year;
    date_result_t  expected_dates[$];
    int            errors;

    function new();
      cur_day   = 1;
      cur_month = 1;
      cur_year  = 16'd2000;
      errors    = 0;
    endfunction

    function bit is_leap_year(logic [15:0] y);
      int unsigned yy;
      yy = y;
      return ((yy % 4) == 0 && (yy % 100) != 0) || ((yy % 400) == 0);
    endfunction

    function int unsigned days_in(int unsigned m, logic [15:0] y);
      int unsigned len;
      case (m)
        2:          len = is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11: len = 30;
        default:    len = 31;
      endcase
      return len;
    endfunction

    // Advance the held date by one accepted request and queue the result
    function void note_request(logic [1:0] f, logic [15:0] n, logic [4:0] nd,
                               logic [3:0] nm, logic [15:0] ny);
      int unsigned  days;
      int unsigned  left;
      int unsigned  d;
      int unsigned  m;
      int unsigned  len;
      logic         wrapped;
      date_result_t r;
      days    = n;
      wrapped = 1'b0;
      case (f)
        dasd_pkg::FUNC_SET: begin
          m = nm;
          if (m < 1) m = 1;
          if (m > 12) m = 12;
          len = days_in(m, ny);
          d = nd;
          if (d < 1) d = 1;
          if (d > len) d = len;
          cur_day   = d;
          cur_month = m;
          cur_year  = ny;
        end
        dasd_pkg::FUNC_ADD: begin
          while (days > 0) begin
            left = days_in(cur_month, cur_year) - cur_day;
            if (days > left) begin
              days -= left + 1;
              cur_day = 1;
              if (cur_month == 12) begin
                cur_month = 1;
                if (cur_year == 16'hFFFF) wrapped = 1'b1;
                cur_year = cur_year + 16'd1;
              end else begin
                cur_month++;
              end
            end else begin
              cur_day += days;
              days = 0;
            end
          end
        end
        dasd_pkg::FUNC_SUB: begin
          while (days > 0) begin
            if (days >= cur_day) begin
              days -= cur_day;
              if (cur_month == 1) begin
                cur_month = 12;
                if (cur_year == 16'h0000) wrapped = 1'b1;
                cur_year = cur_year - 16'd1;
              end else begin
                cur_month--;
              end
              cur_day = days_in(cur_month, cur_year);
            end else begin
              cur_day -= days;
              days = 0;
            end
          end
        end
        default: begin
        end
      endcase
      r.day     = 5'(cur_day);
      r.month   = 4'(cur_month);
      r.year    = cur_year;
      r.wrapped = wrapped;
      expected_dates.push_back(r);
    endfunction

    // Compare one returned date with the oldest queued one
    function void check_result(date_result_t got);
      date_result_t exp_r;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d-%0d-%0d wrap %0d",
                 $time, got.year, got.month, got.day, got.wrapped);
        errors++;
        return;
      end
      exp_r = expected_dates.pop_front();
      if (got.day !== exp_r.day) begin
        $display("%0t: day_out mismatch, expected %0d, got %0d", $time, exp_r.day, got.day);
        errors++;
      end
      if (got.month !== exp_r.month) begin
        $display("%0t: month_out mismatch, expected %0d, got %0d", $time, exp_r.month,
                 got.month);
        errors++;
      end
      if (got.year !== exp_r.year) begin
        $display("%0t: year_out mismatch, expected %0d, got %0d", $time, exp_r.year,
                 got.year);
        errors++;
      end
      if (got.wrapped !== exp_r.wrapped) begin
        $display("%0t: year_wrapped mismatch, expected %0d, got %0d", $time,
                 exp_r.wrapped, got.wrapped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i         = FUNC_NOP;
  logic [15:0] days_count_i   = 16'd0;
  logic [4:0]  new_day_i      = 5'd1;
  logic [3:0]  new_month_i    = 4'd1;
  logic [15:0] new_year_i     = 16'd2000;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [4:0]  day_out_o;
  logic [3:0]  month_out_o;
  logic [15:0] year_out_o;
  logic        year_wrapped_o;

  date_tracker tracker = new();
  int          n_sent    = 0;
  int          n_checked = 0;

  date_add_subtract_days uut (.*);

  // Free-running 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Draw a per-item wait; every fourth stretch of 40 items runs back to back
  function automatic int draw_gap(int idx);
    if ((idx / 40) % 4 == 2) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] f, input logic [15:0] n,
                              input logic [4:0] nd, input logic [3:0] nm,
                              input logic [15:0] ny);
    int gap;
    gap = draw_gap(n_sent);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    days_count_i <= n;
    new_day_i    <= nd;
    new_month_i  <= nm;
    new_year_i   <= ny;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(f, n, nd, nm, ny);
    n_sent++;
  endtask

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return dasd_pkg::FUNC_SET;
    if (r < 55) return dasd_pkg::FUNC_ADD;
    if (r < 90) return dasd_pkg::FUNC_SUB;
    return FUNC_NOP;
  endfunction

  // Mostly short moves; a few reach the full 16-bit count
  function automatic logic [15:0] pick_days();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 60));
    if (r < 80) return 16'($urandom_range(0, 2000));
    if (r < 92) return 16'($urandom_range(0, 20000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Bias years toward the wrap points and century leap rules
  function automatic logic [15:0] pick_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'($urandom_range(0, 65535));
    if (r < 35) return 16'($urandom_range(0, 3));
    if (r < 45) return 16'($urandom_range(65530, 65535));
    if (r < 70) return 16'(100 * $urandom_range(0, 655) + $urandom_range(0, 1));
    return 16'($urandom_range(1890, 2110));
  endfunction

  // Result side: random stalls, one long hold-off, check every result
  initial begin
    int hold;
    date_result_t got;
    wait (rst_ni);
    forever begin
      hold = (n_checked == HOLD_AT) ? HOLD_CYCLES : draw_gap(n_checked + 13);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.day     = day_out_o;
      got.month   = month_out_o;
      got.year    = year_out_o;
      got.wrapped = year_wrapped_o;
      tracker.check_result(got);
      n_checked++;
    end
  end

  // Stimulus: directed corners, then random requests, then drain
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset date, unused code and zero counts
    send_request(FUNC_NOP, 16'hFFFF, 5'd31, 4'd15, 16'hFFFF);
    send_request(dasd_pkg::FUNC_ADD, 16'd0, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SUB, 16'd0, 5'd0, 4'd0, 16'd0);
    // leap day clamping on set
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd29, dasd_pkg::MONTH_FEB, 16'd2000);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd29, dasd_pkg::MONTH_FEB, 16'd1900);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd31, dasd_pkg::MONTH_FEB, 16'd2024);
    // out-of-range day and month on set
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd0, 4'd0, 16'd2023);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd31, 4'd15, 16'd2023);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd31, 4'd4, 16'd2023);
    // year wrap forward and back by one day
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd31, dasd_pkg::MONTH_DEC, 16'hFFFF);
    send_request(dasd_pkg::FUNC_ADD, 16'd1, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SUB, 16'd1, 5'd0, 4'd0, 16'd0);
    // month boundaries around February
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd28, dasd_pkg::MONTH_FEB, 16'd2100);
    send_request(dasd_pkg::FUNC_ADD, 16'd1, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd1, 4'd3, 16'd2000);
    send_request(dasd_pkg::FUNC_SUB, 16'd1, 5'd0, 4'd0, 16'd0);
    // full-range counts, with and without a wrap
    send_request(dasd_pkg::FUNC_ADD, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SUB, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd31, 4'd13, 16'hFFFF);
    send_request(dasd_pkg::FUNC_ADD, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_request(dasd_pkg::FUNC_SET, 16'd0, 5'd15, 4'd6, 16'd0);
    send_request(dasd_pkg::FUNC_SUB, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_request(FUNC_NOP, 16'd0, 5'd0, 4'd0, 16'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_request(pick_func(), pick_days(), 5'($urandom_range(0, 31)),
                   4'($urandom_range(0, 15)), pick_year());
    end
    in_valid_i <= 1'b0;

    // wait out the remaining results, then let stray ones show up
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #16_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
